// ===== rtl/core/brfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfb_pkg
// Shared codes, widths and control structs of the byte ring fifo.
// ----------------------------------------------------------------------------
package brfb_pkg;

  localparam int BYTE_W = 8;
  localparam int BANKS  = 8;   // one byte bank per lane
  localparam int BANK_W = 3;
  localparam int DATA_W = BANKS * BYTE_W;
  localparam int LEN_W  = 4;
  localparam int FILL_W = 9;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_DATA  = 2'd2;

  // per-access control broadcast to every lane
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [BANK_W-1:0] base_low;
    logic [LEN_W-1:0]  len;
  } lane_ctl_t;

  // what travels from the lane read stage to the merge stage
  typedef struct packed {
    logic [1:0]        status;
    logic              rd;
    logic [BANK_W-1:0] rot;
    logic [LEN_W-1:0]  len;
    logic [FILL_W-1:0] fill;
  } s1_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/brfb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfb_in_if / brfb_out_if
// Valid/ready channels carrying burst requests and their results.
// ----------------------------------------------------------------------------
interface brfb_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [brfb_pkg::LEN_W-1:0] length;
  logic [brfb_pkg::DATA_W-1:0] push_bytes;

  modport source (output valid, command, length, push_bytes, input ready);
  modport sink   (input valid, command, length, push_bytes, output ready);
endinterface

interface brfb_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [brfb_pkg::DATA_W-1:0] read_bytes;
  logic [brfb_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, status, read_bytes, fill_count, input ready);
  modport sink   (input valid, status, read_bytes, fill_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brfb_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfb_lane
// One byte bank of the ring: holds every address whose low bits equal the
// lane id, works out its own offset in the burst and writes or reads a byte.
// ----------------------------------------------------------------------------
module brfb_lane #(
  parameter int LANE_ID = 0,
  parameter int PTR_W   = 8
) (
  input  wire                              clk,
  input  wire brfb_pkg::lane_ctl_t         ctl,
  input  wire [PTR_W-1:0]                  base,
  input  wire [brfb_pkg::DATA_W-1:0]       wdata,
  output logic [brfb_pkg::BYTE_W-1:0]      rdata_r
);

  localparam int ROWS  = (1 << PTR_W) / brfb_pkg::BANKS;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [brfb_pkg::BYTE_W-1:0] mem [ROWS];

  logic [brfb_pkg::BANK_W-1:0] off;
  logic [PTR_W-1:0]            addr;
  logic [ROW_W-1:0]            row;
  logic                        act;
  logic [brfb_pkg::BYTE_W-1:0] wbyte;

  // burst position that lands in this bank
  assign off   = brfb_pkg::BANK_W'(LANE_ID) - ctl.base_low;
  assign addr  = base + PTR_W'(off);
  assign row   = (ROWS > 1) ? ROW_W'(addr >> brfb_pkg::BANK_W) : '0;
  assign act   = {1'b0, off} < ctl.len;
  assign wbyte = wdata[off*brfb_pkg::BYTE_W +: brfb_pkg::BYTE_W];

  always_ff @(posedge clk) begin
    if (ctl.wr && act) begin
      mem[row] <= wbyte;
    end
    if (ctl.rd) begin
      rdata_r <= mem[row];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brfb_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfb_merge
// Rotates the bank outputs back into burst order and zeroes lanes beyond
// the length or for accesses that return no data.
// ----------------------------------------------------------------------------
module brfb_merge (
  input  wire [brfb_pkg::DATA_W-1:0]  lanes,
  input  wire brfb_pkg::s1_ctl_t      ctl,
  output logic [brfb_pkg::DATA_W-1:0] read_bytes
);

  always_comb begin
    logic [brfb_pkg::BANK_W-1:0] idx;
    idx        = '0;
    read_bytes = '0;
    for (int j = 0; j < brfb_pkg::BANKS; j++) begin
      idx = ctl.rot + brfb_pkg::BANK_W'(j);
      if (ctl.rd && (brfb_pkg::LEN_W'(j) < ctl.len)) begin
        read_bytes[j*brfb_pkg::BYTE_W +: brfb_pkg::BYTE_W] =
          lanes[idx*brfb_pkg::BYTE_W +: brfb_pkg::BYTE_W];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_burst_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst_unit
// Byte ring fifo with push, pop and peek bursts of up to eight bytes.
// ----------------------------------------------------------------------------
// stages: accepted word passes bank read, then merge, to the result word
// throughput: one word per cycle unless the output is stalled; each of the
// eight byte banks has one port and a burst touches each bank at most once
// reset: pointers, count and all valids cleared; store contents stay
// undefined until pushed, no clearing pass
module byte_ring_fifo_burst_unit #(
  parameter int QUEUE_DEPTH = 256,
  parameter int BURST_BYTES = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  brfb_in_if.sink      in_ch,
  brfb_out_if.source   out_ch
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                     s1_valid_r, s1_valid_nxt;
  brfb_pkg::s1_ctl_t        s1_ctl_r, s1_ctl_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r;
  logic [brfb_pkg::DATA_W-1:0] out_data_r;
  logic [brfb_pkg::FILL_W-1:0] out_fill_r;

  logic                        accept, s1_adv;
  logic [brfb_pkg::LEN_W-1:0]  len_sat;
  logic [CNT_W-1:0]            len_ext, free_cnt;
  logic                        is_push, is_rd, ok;
  logic [1:0]                  status;
  brfb_pkg::lane_ctl_t         lane_ctl;
  logic [PTR_W-1:0]            base;
  logic [brfb_pkg::DATA_W-1:0] lane_rd;
  logic [brfb_pkg::DATA_W-1:0] merged;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign accept       = in_ch.valid && in_ch.ready;

  assign len_sat  = (in_ch.length > brfb_pkg::LEN_W'(BURST_BYTES)) ?
                    brfb_pkg::LEN_W'(BURST_BYTES) : in_ch.length;
  assign len_ext  = CNT_W'(len_sat);
  assign free_cnt = CNT_W'(QUEUE_DEPTH) - cnt_r;
  assign is_push  = in_ch.command == brfb_pkg::CMD_PUSH;
  assign is_rd    = (in_ch.command == brfb_pkg::CMD_POP) ||
                    (in_ch.command == brfb_pkg::CMD_PEEK);

  always_comb begin
    status = brfb_pkg::ST_OK;
    if (is_push && (len_ext > free_cnt)) begin
      status = brfb_pkg::ST_NO_SPACE;
    end else if (is_rd && (len_ext > cnt_r)) begin
      status = brfb_pkg::ST_NO_DATA;
    end
  end
  assign ok = status == brfb_pkg::ST_OK;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (accept && ok && is_push) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(len_sat);
      cnt_nxt    = cnt_r + len_ext;
    end else if (accept && ok && (in_ch.command == brfb_pkg::CMD_POP)) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(len_sat);
      cnt_nxt    = cnt_r - len_ext;
    end
  end

  assign base              = is_push ? wr_ptr_r : rd_ptr_r;
  assign lane_ctl.wr       = accept && ok && is_push;
  assign lane_ctl.rd       = accept && ok && is_rd;
  assign lane_ctl.base_low = base[brfb_pkg::BANK_W-1:0];
  assign lane_ctl.len      = len_sat;

  for (genvar k = 0; k < brfb_pkg::BANKS; k++) begin : g_lane
    brfb_lane #(
      .LANE_ID (k),
      .PTR_W   (PTR_W)
    ) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .base    (base),
      .wdata   (in_ch.push_bytes),
      .rdata_r (lane_rd[k*brfb_pkg::BYTE_W +: brfb_pkg::BYTE_W])
    );
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_ctl_nxt   = s1_ctl_r;
    if (accept) begin
      s1_valid_nxt    = 1'b1;
      s1_ctl_nxt.status = status;
      s1_ctl_nxt.rd   = ok && is_rd;
      s1_ctl_nxt.rot  = rd_ptr_r[brfb_pkg::BANK_W-1:0];
      s1_ctl_nxt.len  = len_sat;
      s1_ctl_nxt.fill = brfb_pkg::FILL_W'(cnt_nxt);
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  brfb_merge u_merge (
    .lanes      (lane_rd),
    .ctl        (s1_ctl_r),
    .read_bytes (merged)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r <= s1_ctl_nxt;
    if (s1_adv) begin
      out_status_r <= s1_ctl_r.status;
      out_data_r   <= merged;
      out_fill_r   <= s1_ctl_r.fill;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_bytes = out_data_r;
  assign out_ch.fill_count = out_fill_r;

  // count never passes the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("stored count above depth");

  // pointer distance matches the stored count
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[PTR_W-1:0])
    else $error("pointer gap differs from count");

  // a failed access never returns bytes
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != brfb_pkg::ST_OK)) |-> (out_data_r == '0))
    else $error("failed access carries data");

  // a stalled middle stage keeps its word
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_ctl_r)))
    else $error("middle stage word lost");

endmodule

`default_nettype wire
